FILE: sv/tvg_pkg.sv
// Shared types and constants of the three-valued gate evaluation engine.
// Command classes, gate codes and the control word between front and back.
// No dependencies.
`default_nettype none

package tvg_pkg;

  // Port field widths
  localparam int unsigned NET_FIELD_W = 10;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned FANIN_W     = 3;
  localparam int unsigned RAIL_PORT_W = 64;

  // Source net fields on the command port
  localparam int unsigned SRC_FIELDS = 4;
  localparam int unsigned SRC_SEL_W  = $clog2(SRC_FIELDS);

  // Largest fanin honored by AND/OR type gates
  localparam int unsigned MAX_FANIN   = 4;
  localparam int unsigned FANIN_LIMIT = (MAX_FANIN < SRC_FIELDS) ? MAX_FANIN : SRC_FIELDS;
  localparam int unsigned CNT_W       = $clog2(SRC_FIELDS + 1);

  // Default sizes of the net store
  localparam int unsigned NET_COUNT_DEF    = 1024;
  localparam int unsigned PATTERN_BITS_DEF = 64;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic {
    FN_LOAD = 1'b0,
    FN_EVAL = 1'b1
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    GK_BRANCH = 4'd0,
    GK_BUF    = 4'd1,
    GK_INV    = 4'd2,
    GK_AND    = 4'd3,
    GK_NAND   = 4'd4,
    GK_OR     = 4'd5,
    GK_NOR    = 4'd6,
    GK_XOR    = 4'd7,
    GK_XNOR   = 4'd8
  } gate_kind_e;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_COPY = 3'd1,
    OP_AND  = 3'd2,
    OP_OR   = 3'd3,
    OP_XOR  = 3'd4
  } op_e;

  // Decoded command: operation class, output inversion, number of source reads
  typedef struct packed {
    op_e              op;
    logic             inv;
    logic [CNT_W-1:0] reads;
  } cmd_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/three_valued_gate_eval_engine_unit.sv
// Top level of the three-valued gate evaluation engine: front decoder,
// command queue, back sequencer and net store. Depends on tvg_pkg.
//
//   Channel   Handshake            Fields
//   command   push / full          func, gate_kind, out_net, src_net_a..d,
//                                  fanin_count, load_xrail, load_prail
//   result    empty / pop          written_net, result_xrail, result_prail
//
// In the back sequencer a load goes from idle straight to the done state; an
// evaluate passes through the read state for reads source words, where reads
// is 1 for branch/buf/inv, 2 for xor/xnor and the saturated fanin for and/or
// types. The single read port of the net store fetches one source word per
// cycle. The two-entry command queue keeps accepting while the back works or
// the result waits. Reset clears control state only; the store is not cleared.
`default_nettype none

module three_valued_gate_eval_engine_unit import tvg_pkg::*; #(
  parameter int unsigned NetCount    = NET_COUNT_DEF,
  parameter int unsigned PatternBits = PATTERN_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   func_i,
  input  logic [KIND_W-1:0]      gate_kind_i,
  input  logic [NET_FIELD_W-1:0] out_net_i,
  input  logic [NET_FIELD_W-1:0] src_net_a_i,
  input  logic [NET_FIELD_W-1:0] src_net_b_i,
  input  logic [NET_FIELD_W-1:0] src_net_c_i,
  input  logic [NET_FIELD_W-1:0] src_net_d_i,
  input  logic [FANIN_W-1:0]     fanin_count_i,
  input  logic [RAIL_PORT_W-1:0] load_xrail_i,
  input  logic [RAIL_PORT_W-1:0] load_prail_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [NET_FIELD_W-1:0] written_net_o,
  output logic [RAIL_PORT_W-1:0] result_xrail_o,
  output logic [RAIL_PORT_W-1:0] result_prail_o
);

  localparam int unsigned IdxW   = $clog2(NetCount);
  localparam int unsigned CtrlW  = $bits(cmd_ctrl_t);
  localparam int unsigned QWidth = CtrlW + IdxW * (1 + SRC_FIELDS) + 2 * PatternBits;

  cmd_ctrl_t                       f_ctrl, q_ctrl;
  logic [IdxW-1:0]                 f_dst, q_dst;
  logic [SRC_FIELDS-1:0][IdxW-1:0] f_src, q_src;
  logic [PatternBits-1:0]          f_ldx, f_ldp, q_ldx, q_ldp;
  logic [QWidth-1:0]               q_wdata, q_rdata;
  logic                            q_valid, q_pop;

  logic                            ram_we, ram_re;
  logic [IdxW-1:0]                 ram_waddr, ram_raddr;
  logic [2*PatternBits-1:0]        ram_wdata, ram_rdata;

  logic                            out_valid;
  logic [IdxW-1:0]                 out_net;
  logic [PatternBits-1:0]          out_x, out_p;

  tvg_front #(
    .NetCount    (NetCount),
    .PatternBits (PatternBits)
  ) u_front (
    .func_i        (func_i),
    .gate_kind_i   (gate_kind_i),
    .out_net_i     (out_net_i),
    .src_net_a_i   (src_net_a_i),
    .src_net_b_i   (src_net_b_i),
    .src_net_c_i   (src_net_c_i),
    .src_net_d_i   (src_net_d_i),
    .fanin_count_i (fanin_count_i),
    .load_xrail_i  (load_xrail_i),
    .load_prail_i  (load_prail_i),
    .ctrl_o        (f_ctrl),
    .dst_o         (f_dst),
    .src_o         (f_src),
    .ldx_o         (f_ldx),
    .ldp_o         (f_ldp)
  );

  // Pack decoded command into a queue word
  assign q_wdata = {f_ctrl, f_dst, f_src, f_ldx, f_ldp};
  assign {q_ctrl, q_dst, q_src, q_ldx, q_ldp} = q_rdata;

  tvg_cmdq #(
    .Width (QWidth),
    .Depth (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  tvg_back #(
    .NetCount    (NetCount),
    .PatternBits (PatternBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_ctrl_i    (q_ctrl),
    .q_dst_i     (q_dst),
    .q_src_i     (q_src),
    .q_ldx_i     (q_ldx),
    .q_ldp_i     (q_ldp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_net_o   (out_net),
    .out_x_o     (out_x),
    .out_p_o     (out_p)
  );

  tvg_ram #(
    .Width (2 * PatternBits),
    .Depth (NetCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result ports, zero-extended to port width
  assign empty          = !out_valid;
  assign written_net_o  = NET_FIELD_W'(out_net);
  assign result_xrail_o = RAIL_PORT_W'(out_x);
  assign result_prail_o = RAIL_PORT_W'(out_p);

endmodule

`default_nettype wire

FILE: sv/tvg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the dual-rail net values. No dependencies.
`default_nettype none

module tvg_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/tvg_cmdq.sv
// Small command queue between the front decoder and the back sequencer.
// Depends on tvg_pkg for the default depth.
`default_nettype none

module tvg_cmdq import tvg_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = CMDQ_DEPTH,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tvg_front.sv
// Front decoder: classifies a command, reduces net indices into the store
// and saturates the fanin. Depends on tvg_pkg.
`default_nettype none

module tvg_front import tvg_pkg::*; #(
  parameter int unsigned NetCount    = NET_COUNT_DEF,
  parameter int unsigned PatternBits = PATTERN_BITS_DEF,
  localparam int unsigned IdxW = $clog2(NetCount)
) (
  input  logic                             func_i,
  input  logic [KIND_W-1:0]                gate_kind_i,
  input  logic [NET_FIELD_W-1:0]           out_net_i,
  input  logic [NET_FIELD_W-1:0]           src_net_a_i,
  input  logic [NET_FIELD_W-1:0]           src_net_b_i,
  input  logic [NET_FIELD_W-1:0]           src_net_c_i,
  input  logic [NET_FIELD_W-1:0]           src_net_d_i,
  input  logic [FANIN_W-1:0]               fanin_count_i,
  input  logic [RAIL_PORT_W-1:0]           load_xrail_i,
  input  logic [RAIL_PORT_W-1:0]           load_prail_i,
  output cmd_ctrl_t                        ctrl_o,
  output logic [IdxW-1:0]                  dst_o,
  output logic [SRC_FIELDS-1:0][IdxW-1:0]  src_o,
  output logic [PatternBits-1:0]           ldx_o,
  output logic [PatternBits-1:0]           ldp_o
);

  // Reduce a raw net field modulo the store depth by restoring subtraction
  function automatic logic [IdxW-1:0] reduce_net(input logic [NET_FIELD_W-1:0] raw);
    logic [31:0] r;
    logic [31:0] step;
    r = 32'(raw);
    for (int k = NET_FIELD_W - 1; k >= 0; k--) begin
      step = 32'(NetCount) << k;
      if (r >= step) begin
        r = r - step;
      end
    end
    return r[IdxW-1:0];
  endfunction

  gate_kind_e       kind;
  logic [CNT_W-1:0] fanin_sat;

  assign kind = gate_kind_e'(gate_kind_i);

  // Net indices
  assign dst_o    = reduce_net(out_net_i);
  assign src_o[0] = reduce_net(src_net_a_i);
  assign src_o[1] = reduce_net(src_net_b_i);
  assign src_o[2] = reduce_net(src_net_c_i);
  assign src_o[3] = reduce_net(src_net_d_i);

  // Load words trimmed to the pattern width
  assign ldx_o = load_xrail_i[PatternBits-1:0];
  assign ldp_o = load_prail_i[PatternBits-1:0];

  // Zero fanin counts as one, large fanin saturates
  always_comb begin
    if (fanin_count_i == '0) begin
      fanin_sat = CNT_W'(1);
    end else if (CNT_W'(fanin_count_i) > CNT_W'(FANIN_LIMIT)) begin
      fanin_sat = CNT_W'(FANIN_LIMIT);
    end else begin
      fanin_sat = CNT_W'(fanin_count_i);
    end
  end

  // Classify the command
  always_comb begin
    ctrl_o.inv   = kind inside {GK_INV, GK_NAND, GK_NOR, GK_XNOR};
    ctrl_o.op    = OP_COPY;
    ctrl_o.reads = CNT_W'(1);
    case (kind)
      GK_AND, GK_NAND: begin
        ctrl_o.op    = OP_AND;
        ctrl_o.reads = fanin_sat;
      end
      GK_OR, GK_NOR: begin
        ctrl_o.op    = OP_OR;
        ctrl_o.reads = fanin_sat;
      end
      GK_XOR, GK_XNOR: begin
        ctrl_o.op    = OP_XOR;
        ctrl_o.reads = CNT_W'(2);
      end
      default: begin
        ctrl_o.op    = OP_COPY;
        ctrl_o.reads = CNT_W'(1);
      end
    endcase
    if (func_e'(func_i) == FN_LOAD) begin
      ctrl_o.op    = OP_LOAD;
      ctrl_o.inv   = 1'b0;
      ctrl_o.reads = '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tvg_back.sv
// Back sequencer: reads source nets one per cycle, folds them into the gate
// value, writes the output net and holds the result. Depends on tvg_pkg.
`default_nettype none

module tvg_back import tvg_pkg::*; #(
  parameter int unsigned NetCount    = NET_COUNT_DEF,
  parameter int unsigned PatternBits = PATTERN_BITS_DEF,
  localparam int unsigned IdxW = $clog2(NetCount)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command queue head
  input  logic                            q_valid_i,
  output logic                            q_pop_o,
  input  cmd_ctrl_t                       q_ctrl_i,
  input  logic [IdxW-1:0]                 q_dst_i,
  input  logic [SRC_FIELDS-1:0][IdxW-1:0] q_src_i,
  input  logic [PatternBits-1:0]          q_ldx_i,
  input  logic [PatternBits-1:0]          q_ldp_i,
  // net store
  output logic                            ram_we_o,
  output logic [IdxW-1:0]                 ram_waddr_o,
  output logic [2*PatternBits-1:0]        ram_wdata_o,
  output logic                            ram_re_o,
  output logic [IdxW-1:0]                 ram_raddr_o,
  input  logic [2*PatternBits-1:0]        ram_rdata_i,
  // result slot
  output logic                            out_valid_o,
  input  logic                            out_pop_i,
  output logic [IdxW-1:0]                 out_net_o,
  output logic [PatternBits-1:0]          out_x_o,
  output logic [PatternBits-1:0]          out_p_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  cmd_ctrl_t                       ctrl_q, ctrl_d;
  logic [IdxW-1:0]                 dst_q, dst_d;
  logic [SRC_FIELDS-1:0][IdxW-1:0] src_q, src_d;
  logic [PatternBits-1:0]          ldx_q, ldx_d, ldp_q, ldp_d;
  logic [CNT_W-1:0]                rd_cnt_q, rd_cnt_d;
  logic                            rd_vld_q, rd_vld_d;
  logic                            have_q, have_d;
  logic [PatternBits-1:0]          acc_x_q, acc_x_d, acc_p_q, acc_p_d;
  logic                            out_vld_q, out_vld_d;
  logic [IdxW-1:0]                 out_net_q, out_net_d;
  logic [PatternBits-1:0]          out_x_q, out_x_d, out_p_q, out_p_d;

  logic [PatternBits-1:0]          rd_x, rd_p;
  logic [PatternBits-1:0]          step_x, step_p;
  logic [PatternBits-1:0]          val_x, val_p;
  logic [PatternBits-1:0]          fin_x, fin_p;
  logic                            out_free;

  assign rd_x = ram_rdata_i[2*PatternBits-1:PatternBits];
  assign rd_p = ram_rdata_i[PatternBits-1:0];

  // Fold the arriving source word into the running gate value
  always_comb begin
    step_x = rd_x;
    step_p = rd_p;
    if (have_q) begin
      case (ctrl_q.op)
        OP_AND: begin
          step_x = acc_x_q & rd_x;
          step_p = acc_p_q | rd_p;
        end
        OP_OR: begin
          step_x = acc_x_q | rd_x;
          step_p = acc_p_q & rd_p;
        end
        OP_XOR: begin
          step_x = (acc_x_q & rd_p) | (acc_p_q & rd_x);
          step_p = (acc_p_q | rd_x) & (acc_x_q | rd_p);
        end
        default: begin
          step_x = rd_x;
          step_p = rd_p;
        end
      endcase
    end
  end

  // Final value: load words or gate value, rails swapped for inversion
  always_comb begin
    if (ctrl_q.op == OP_LOAD) begin
      val_x = ldx_q;
      val_p = ldp_q;
    end else begin
      val_x = step_x;
      val_p = step_p;
    end
    fin_x = ctrl_q.inv ? val_p : val_x;
    fin_p = ctrl_q.inv ? val_x : val_p;
  end

  assign out_free = !out_vld_q || out_pop_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ctrl_d    = ctrl_q;
    dst_d     = dst_q;
    src_d     = src_q;
    ldx_d     = ldx_q;
    ldp_d     = ldp_q;
    rd_cnt_d  = rd_cnt_q;
    rd_vld_d  = rd_vld_q;
    have_d    = have_q;
    acc_x_d   = acc_x_q;
    acc_p_d   = acc_p_q;
    out_vld_d = out_vld_q;
    out_net_d = out_net_q;
    out_x_d   = out_x_q;
    out_p_d   = out_p_q;
    q_pop_o   = 1'b0;
    ram_we_o  = 1'b0;
    ram_re_o  = 1'b0;

    // drop the result once taken
    if (out_pop_i && out_vld_q) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          ctrl_d   = q_ctrl_i;
          dst_d    = q_dst_i;
          src_d    = q_src_i;
          ldx_d    = q_ldx_i;
          ldp_d    = q_ldp_i;
          rd_cnt_d = '0;
          rd_vld_d = 1'b0;
          have_d   = 1'b0;
          state_d  = (q_ctrl_i.op == OP_LOAD) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
        rd_cnt_d = rd_cnt_q + CNT_W'(1);
        rd_vld_d = 1'b1;
        if (rd_vld_q) begin
          acc_x_d = step_x;
          acc_p_d = step_p;
          have_d  = 1'b1;
        end
        if (rd_cnt_q == ctrl_q.reads - CNT_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // last source word stays on the read port until the slot frees
        if (out_free) begin
          ram_we_o  = 1'b1;
          out_vld_d = 1'b1;
          out_net_d = dst_q;
          out_x_d   = fin_x;
          out_p_d   = fin_p;
          rd_vld_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_raddr_o = src_q[rd_cnt_q[SRC_SEL_W-1:0]];
  assign ram_waddr_o = dst_q;
  assign ram_wdata_o = {fin_x, fin_p};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_vld_q  <= rd_vld_d;
      have_q    <= have_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ctrl_q    <= ctrl_d;
    dst_q     <= dst_d;
    src_q     <= src_d;
    ldx_q     <= ldx_d;
    ldp_q     <= ldp_d;
    acc_x_q   <= acc_x_d;
    acc_p_q   <= acc_p_d;
    out_net_q <= out_net_d;
    out_x_q   <= out_x_d;
    out_p_q   <= out_p_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_net_o   = out_net_q;
  assign out_x_o     = out_x_q;
  assign out_p_o     = out_p_q;

endmodule

`default_nettype wire

FILE: sv/tvg_chk.sv
// Port-level checker for the three-valued gate evaluation engine, bound to
// the top level. Depends on tvg_pkg for field widths.
`default_nettype none

module tvg_chk import tvg_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push,
  input logic                   full,
  input logic                   func_i,
  input logic                   empty,
  input logic                   pop,
  input logic [NET_FIELD_W-1:0] written_net_o,
  input logic [RAIL_PORT_W-1:0] result_xrail_o,
  input logic [RAIL_PORT_W-1:0] result_prail_o
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // Track commands accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(written_net_o) &&
                          $stable(result_xrail_o) && $stable(result_prail_o)))
    else $error("result changed while waiting");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != 3'd0))
    else $error("result shown with no command outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more commands in flight than queue and sequencer hold");

  a_full_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (pend_q >= 3'd2))
    else $error("full raised with queue not occupied");

  a_load_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !func_i && pend_q == 3'd0) |-> ##3 !empty)
    else $error("load on idle block not answered in three cycles");

endmodule

bind three_valued_gate_eval_engine_unit tvg_chk u_tvg_chk (.*);

`default_nettype wire

FILE: bench/net_value_check_pkg.sv
// Command and result word types plus the net-value scoreboard for the
// three-valued gate evaluation engine bench. Depends on tvg_pkg.
package net_value_check_pkg;
  import tvg_pkg::*;

  // One command word as it goes over the push/full side
  typedef struct packed {
    func_e                                  func;
    logic [KIND_W-1:0]                      kind;
    logic [NET_FIELD_W-1:0]                 dst;
    logic [SRC_FIELDS-1:0][NET_FIELD_W-1:0] src;
    logic [FANIN_W-1:0]                     fanin;
    logic [RAIL_PORT_W-1:0]                 lx;
    logic [RAIL_PORT_W-1:0]                 lp;
  } net_cmd_t;

  // One result word as it comes out on the empty/pop side
  typedef struct packed {
    logic [NET_FIELD_W-1:0] net;
    logic [RAIL_PORT_W-1:0] xr;
    logic [RAIL_PORT_W-1:0] pr;
  } net_result_t;

  class net_value_scoreboard;
    logic [RAIL_PORT_W-1:0] xr_store [NET_COUNT_DEF];
    logic [RAIL_PORT_W-1:0] pr_store [NET_COUNT_DEF];
    net_result_t            net_writes_q [$];
    int unsigned            checked;
    int unsigned            mismatches;

    function new();
      checked    = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return net_writes_q.size();
    endfunction

    // Apply an accepted command to the shadow store and queue the net write
    function void note_cmd(net_cmd_t c);
      logic [RAIL_PORT_W-1:0] xr, pr, bx, bp, t;
      int unsigned            n, i;
      net_result_t            r;
      if (c.func == FN_LOAD) begin
        xr = c.lx;
        pr = c.lp;
      end else begin
        // Clamp fanin: zero counts as one, saturate at the limit
        n = c.fanin;
        if (n == 0) n = 1;
        if (n > FANIN_LIMIT) n = FANIN_LIMIT;
        xr = xr_store[c.src[0]];
        pr = pr_store[c.src[0]];
        bx = xr_store[c.src[1]];
        bp = pr_store[c.src[1]];
        case (c.kind)
          GK_INV: begin
            t = xr; xr = pr; pr = t;
          end
          GK_AND, GK_NAND: begin
            for (i = 1; i < n; i++) begin
              xr &= xr_store[c.src[i]];
              pr |= pr_store[c.src[i]];
            end
            if (c.kind == GK_NAND) begin
              t = xr; xr = pr; pr = t;
            end
          end
          GK_OR, GK_NOR: begin
            for (i = 1; i < n; i++) begin
              xr |= xr_store[c.src[i]];
              pr &= pr_store[c.src[i]];
            end
            if (c.kind == GK_NOR) begin
              t = xr; xr = pr; pr = t;
            end
          end
          GK_XOR, GK_XNOR: begin
            // Two-input only, fanin does not matter
            t  = (xr & bp) | (pr & bx);
            pr = (pr | bx) & (xr | bp);
            xr = t;
            if (c.kind == GK_XNOR) begin
              t = xr; xr = pr; pr = t;
            end
          end
          // Branch, buf and unknown kinds copy source a
          default: ;
        endcase
      end
      xr_store[c.dst] = xr;
      pr_store[c.dst] = pr;
      r.net = c.dst;
      r.xr  = xr;
      r.pr  = pr;
      net_writes_q.push_back(r);
    endfunction

    // Compare a popped result word against the oldest queued net write
    function void check_word(logic [NET_FIELD_W-1:0] net, logic [RAIL_PORT_W-1:0] xr,
                             logic [RAIL_PORT_W-1:0] pr);
      net_result_t exp_r;
      if (net_writes_q.size() == 0) begin
        $error("result word for net %0d arrived with nothing queued", net);
        mismatches++;
        return;
      end
      exp_r = net_writes_q.pop_front();
      checked++;
      if (net !== exp_r.net) begin
        $error("written_net mismatch: expected %0d, actual %0d", exp_r.net, net);
        mismatches++;
      end
      if (xr !== exp_r.xr) begin
        $error("result_xrail mismatch: expected %h, actual %h", exp_r.xr, xr);
        mismatches++;
      end
      if (pr !== exp_r.pr) begin
        $error("result_prail mismatch: expected %h, actual %h", exp_r.pr, pr);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: bench/three_valued_gate_eval_engine_unit_tb.sv
// Self-checking bench for three_valued_gate_eval_engine_unit: directed and
// random load/evaluate words, random idling on both sides, shadow net store.
// Depends on tvg_pkg and net_value_check_pkg.
module three_valued_gate_eval_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvg_pkg::*;
  import net_value_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_TAIL  = 12;
  localparam int unsigned HOLD_STRETCH = 300;
  // Gate codes past the defined set; the block treats them as branch
  localparam logic [KIND_W-1:0] GK_UNUSED_LO = 4'd9;
  localparam logic [KIND_W-1:0] GK_UNUSED_HI = 4'd15;
  localparam logic [FANIN_W-1:0] FANIN_ZERO = 3'd0;
  localparam logic [FANIN_W-1:0] FANIN_TOP  = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic                   func_i;
  logic [KIND_W-1:0]      gate_kind_i;
  logic [NET_FIELD_W-1:0] out_net_i;
  logic [NET_FIELD_W-1:0] src_net_a_i;
  logic [NET_FIELD_W-1:0] src_net_b_i;
  logic [NET_FIELD_W-1:0] src_net_c_i;
  logic [NET_FIELD_W-1:0] src_net_d_i;
  logic [FANIN_W-1:0]     fanin_count_i;
  logic [RAIL_PORT_W-1:0] load_xrail_i;
  logic [RAIL_PORT_W-1:0] load_prail_i;
  logic                   empty;
  logic                   pop;
  logic [NET_FIELD_W-1:0] written_net_o;
  logic [RAIL_PORT_W-1:0] result_xrail_o;
  logic [RAIL_PORT_W-1:0] result_prail_o;

  net_value_scoreboard    sb;
  int unsigned            send_idle_pct;
  int unsigned            recv_idle_pct;
  int unsigned            hold_cycles;
  int unsigned            n_loads;
  int unsigned            n_evals;

  // Nets written so far; evaluates only read from these
  bit                     net_written [NET_COUNT_DEF];
  int unsigned            written_list [$];
  logic [NET_FIELD_W-1:0] last_dst;

  three_valued_gate_eval_engine_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .gate_kind_i    (gate_kind_i),
    .out_net_i      (out_net_i),
    .src_net_a_i    (src_net_a_i),
    .src_net_b_i    (src_net_b_i),
    .src_net_c_i    (src_net_c_i),
    .src_net_d_i    (src_net_d_i),
    .fanin_count_i  (fanin_count_i),
    .load_xrail_i   (load_xrail_i),
    .load_prail_i   (load_prail_i),
    .empty          (empty),
    .pop            (pop),
    .written_net_o  (written_net_o),
    .result_xrail_o (result_xrail_o),
    .result_prail_o (result_prail_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("cycle limit of %0d reached", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random pop, or a counted hold-off stretch when requested
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every popped result word
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_word(written_net_o, result_xrail_o, result_prail_o);
    end
  end

  // Record a write to the net bookkeeping used for source selection
  function automatic void mark_written(logic [NET_FIELD_W-1:0] dst);
    if (!net_written[dst]) begin
      net_written[dst] = 1'b1;
      written_list.push_back(dst);
    end
    last_dst = dst;
  endfunction

  // Build a load word; the ignored fields get random junk
  function automatic net_cmd_t mk_load(logic [NET_FIELD_W-1:0] dst, logic [RAIL_PORT_W-1:0] xr,
                                       logic [RAIL_PORT_W-1:0] pr);
    net_cmd_t c;
    c.func  = FN_LOAD;
    c.kind  = KIND_W'($urandom_range(15));
    c.dst   = dst;
    c.src   = {NET_FIELD_W'($urandom), NET_FIELD_W'($urandom),
               NET_FIELD_W'($urandom), NET_FIELD_W'($urandom)};
    c.fanin = FANIN_W'($urandom_range(7));
    c.lx    = xr;
    c.lp    = pr;
    mark_written(dst);
    n_loads++;
    return c;
  endfunction

  function automatic net_cmd_t mk_eval(logic [KIND_W-1:0] kind, logic [NET_FIELD_W-1:0] dst,
                                       logic [NET_FIELD_W-1:0] a, logic [NET_FIELD_W-1:0] b,
                                       logic [NET_FIELD_W-1:0] cc, logic [NET_FIELD_W-1:0] d,
                                       logic [FANIN_W-1:0] fanin);
    net_cmd_t c;
    c.func  = FN_EVAL;
    c.kind  = kind;
    c.dst   = dst;
    c.src   = {d, cc, b, a};
    c.fanin = fanin;
    c.lx    = {$urandom, $urandom};
    c.lp    = {$urandom, $urandom};
    mark_written(dst);
    n_evals++;
    return c;
  endfunction

  // Mostly legal 0/1/X patterns, sometimes raw words with the unused encoding
  function automatic void make_rails(output logic [RAIL_PORT_W-1:0] xr,
                                     output logic [RAIL_PORT_W-1:0] pr);
    logic [RAIL_PORT_W-1:0] v, u;
    v = {$urandom, $urandom};
    u = {$urandom, $urandom} & {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        xr = {$urandom, $urandom};
        pr = {$urandom, $urandom};
      end
      1: begin
        xr = '1;
        pr = '1;
      end
      default: begin
        xr = v | u;
        pr = ~v | u;
      end
    endcase
  endfunction

  // Prefer the net just written, to hit back-to-back dependencies
  function automatic logic [NET_FIELD_W-1:0] pick_src();
    if ($urandom_range(99) < 25) return last_dst;
    return NET_FIELD_W'(written_list[$urandom_range(written_list.size() - 1)]);
  endfunction

  function automatic net_cmd_t make_random_cmd();
    logic [RAIL_PORT_W-1:0] xr, pr;
    logic [KIND_W-1:0]      kind;
    logic [NET_FIELD_W-1:0] a, b, cc, d, dst;
    if ($urandom_range(99) < 25) begin
      make_rails(xr, pr);
      return mk_load(NET_FIELD_W'($urandom), xr, pr);
    end
    if ($urandom_range(9) == 0) kind = KIND_W'($urandom_range(15));
    else kind = KIND_W'($urandom_range(GK_XNOR));
    a  = pick_src();
    b  = ($urandom_range(9) == 0) ? a : pick_src();
    cc = pick_src();
    d  = pick_src();
    case ($urandom_range(19))
      0, 1, 2: dst = a;
      3, 4:    dst = NET_FIELD_W'(written_list[$urandom_range(written_list.size() - 1)]);
      default: dst = NET_FIELD_W'($urandom);
    endcase
    return mk_eval(kind, dst, a, b, cc, d, FANIN_W'($urandom_range(7)));
  endfunction

  // Offer one word after random idle cycles; hold it until accepted
  task automatic send_cmd(net_cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    func_i        <= c.func;
    gate_kind_i   <= c.kind;
    out_net_i     <= c.dst;
    src_net_a_i   <= c.src[0];
    src_net_b_i   <= c.src[1];
    src_net_c_i   <= c.src[2];
    src_net_d_i   <= c.src[3];
    fanin_count_i <= c.fanin;
    load_xrail_i  <= c.lx;
    load_prail_i  <= c.lp;
    push          <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_cmd(c);
  endtask

  // Stop offering and wait until every queued net write has been popped
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_cmd(make_random_cmd());
  endtask

  // Extremes of the fields, every gate kind, fanin clamping, unknown kinds
  task automatic run_directed();
    // Seed nets with all-0, all-1, all-X, mixed and raw patterns
    send_cmd(mk_load(10'd0, '0, '1));
    send_cmd(mk_load(10'd1023, '1, '0));
    send_cmd(mk_load(10'h155, '1, '1));
    send_cmd(mk_load(10'h2AA, 64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_0000_FFFF_FFFF));
    send_cmd(mk_load(10'h1F0, 64'h5555_5555_AAAA_AAAA, 64'h3333_CCCC_3333_CCCC));
    send_cmd(mk_eval(GK_BRANCH, 10'd1, 10'h2AA, 10'd0, 10'd0, 10'd0, FANIN_ZERO));
    send_cmd(mk_eval(GK_BUF, 10'd2, 10'h1F0, 10'd1023, 10'h155, 10'h2AA, FANIN_TOP));
    send_cmd(mk_eval(GK_INV, 10'd3, 10'h2AA, 10'h1F0, 10'd0, 10'd0, 3'd1));
    send_cmd(mk_eval(GK_AND, 10'd4, 10'h2AA, 10'd0, 10'h155, 10'd1023, FANIN_ZERO));
    send_cmd(mk_eval(GK_AND, 10'd5, 10'h2AA, 10'd1023, 10'h155, 10'h1F0, 3'd4));
    send_cmd(mk_eval(GK_NAND, 10'd6, 10'd1023, 10'h2AA, 10'h1F0, 10'h155, FANIN_TOP));
    send_cmd(mk_eval(GK_OR, 10'd7, 10'd0, 10'h2AA, 10'd1023, 10'd1023, 3'd2));
    send_cmd(mk_eval(GK_NOR, 10'd8, 10'd0, 10'h155, 10'h1F0, 10'd1023, 3'd3));
    send_cmd(mk_eval(GK_OR, 10'd9, 10'h1F0, 10'h2AA, 10'h155, 10'd0, 3'd4));
    send_cmd(mk_eval(GK_XOR, 10'd10, 10'h2AA, 10'h1F0, 10'd0, 10'd0, 3'd1));
    send_cmd(mk_eval(GK_XNOR, 10'd11, 10'h155, 10'h2AA, 10'd1023, 10'd0, 3'd4));
    send_cmd(mk_eval(GK_UNUSED_LO, 10'd12, 10'h2AA, 10'd0, 10'd0, 10'd0, 3'd3));
    send_cmd(mk_eval(GK_UNUSED_HI, 10'd1023, 10'h1F0, 10'd0, 10'd0, 10'd0, 3'd2));
    // Overwrite a source in place, then a dependent chain
    send_cmd(mk_eval(GK_AND, 10'h2AA, 10'h2AA, 10'd1, 10'd0, 10'd0, 3'd2));
    send_cmd(mk_eval(GK_INV, 10'd13, 10'd3, 10'd0, 10'd0, 10'd0, 3'd1));
    send_cmd(mk_eval(GK_BUF, 10'd14, 10'd13, 10'd0, 10'd0, 10'd0, 3'd1));
    send_cmd(mk_eval(GK_XOR, 10'd15, 10'd14, 10'd14, 10'd0, 10'd0, 3'd2));
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    push          = 1'b0;
    func_i        = FN_LOAD;
    gate_kind_i   = GK_BRANCH;
    out_net_i     = '0;
    src_net_a_i   = '0;
    src_net_b_i   = '0;
    src_net_c_i   = '0;
    src_net_d_i   = '0;
    fanin_count_i = '0;
    load_xrail_i  = '0;
    load_prail_i  = '0;
    hold_cycles   = 0;
    n_loads       = 0;
    n_evals       = 0;
    send_idle_pct = 7;
    recv_idle_pct = 71;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Busy sender, sparse receiver
    run_directed();
    run_random(600);
    drain_results();

    // Sparse sender, busy receiver
    send_idle_pct = 71;
    recv_idle_pct = 7;
    run_random(650);
    drain_results();

    // Full rate, opened by a long receiver hold-off to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = HOLD_STRETCH;
    run_random(650);
    drain_results();

    $display("Covered %0d words (%0d loads, %0d evaluates) over three idling phases",
             n_loads + n_evals, n_loads, n_evals);
    $display("Checked %0d result words, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
